// ----- hw/rtl/fspa_pkg.sv -----
package fspa_pkg;

    localparam int ADDR_W         = 48;
    localparam int OBJ_W          = 17;
    localparam int UNIT_W         = 15;
    localparam int STAT_W         = 2;
    localparam int KIND_W         = 2;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 48;
    localparam int POOL_SLOTS_DEF = 1024;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_OOB   = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE = 1'b0,
        REG_OBJ  = 1'b1
    } t_cfg_reg;

    typedef enum logic [KIND_W-1:0] {
        K_ALLOC = 2'd0,
        K_FREE  = 2'd1,
        K_OOB   = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_ALLOC_FIN,
        S_DIV,
        S_FREE_FIN,
        S_REPLY
    } t_state;

endpackage

// ----- hw/rtl/fspa_if.sv -----
interface fspa_in_if import fspa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              mode;
    logic [ADDR_W-1:0] free_address;

    modport source (output valid, mode, free_address, input ready);
    modport sink (input valid, mode, free_address, output ready);
endinterface

interface fspa_out_if import fspa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] slot_address;
    t_status           status;

    modport source (output valid, slot_address, status, input ready);
    modport sink (input valid, slot_address, status, output ready);
endinterface

interface fspa_cfg_if import fspa_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/fspa_front.sv -----
module fspa_front import fspa_pkg::*; #(
    parameter int POOL_SLOTS = POOL_SLOTS_DEF,
    localparam int LW = $clog2(POOL_SLOTS + 1),
    localparam int SPAN_W = UNIT_W + LW
) (
    fspa_in_if.sink           i_in,
    input  logic [ADDR_W-1:0] i_base,
    input  logic [UNIT_W-1:0] i_units,
    input  logic              i_hold,
    input  logic              i_q_ready,
    output logic              o_push,
    output t_kind             o_kind,
    output logic [SPAN_W-1:0] o_offset
);

    logic [SPAN_W-1:0] span;
    logic [ADDR_W:0]   diff;
    logic [ADDR_W-4:0] unit_off;
    logic              too_far;

    // Pool span in units of eight bytes.
    assign span = SPAN_W'(i_units) * SPAN_W'(POOL_SLOTS);

    always_comb begin
        diff     = {1'b0, i_in.free_address} - {1'b0, i_base};
        unit_off = diff[ADDR_W-1:3];
        too_far  = unit_off >= (ADDR_W-3)'(span);
        priority if (!i_in.mode) begin
            o_kind = K_ALLOC;
        end else if (diff[ADDR_W] || too_far) begin
            o_kind = K_OOB;
        end else begin
            o_kind = K_FREE;
        end
    end

    assign i_in.ready = !i_hold && i_q_ready;
    assign o_push     = i_in.valid && i_in.ready;
    assign o_offset   = unit_off[SPAN_W-1:0];

endmodule

// ----- hw/rtl/fspa_queue.sv -----
module fspa_queue #(
    parameter int DW = 1,
    localparam int DEPTH = 2,
    localparam int PW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_wdata,
    output logic          o_ready,
    input  logic          i_pop,
    output logic          o_valid,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_word [DEPTH];
    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_rp, n_rp;
    logic [CW-1:0] r_cnt, n_cnt;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = r_rp + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_word[r_wp] <= i_wdata;
        end
    end

    assign o_ready = r_cnt != CW'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_rdata = r_word[r_rp];

endmodule

// ----- hw/rtl/fspa_div.sv -----
module fspa_div import fspa_pkg::*; #(
    parameter int POOL_SLOTS = POOL_SLOTS_DEF,
    localparam int LW = $clog2(POOL_SLOTS + 1),
    localparam int SPAN_W = UNIT_W + LW,
    localparam int AW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1,
    localparam int CW = $clog2(AW + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SPAN_W-1:0] i_dividend,
    input  logic [UNIT_W-1:0] i_divisor,
    output logic              o_done,
    output logic [AW-1:0]     o_quot
);

    logic [SPAN_W-1:0] r_rem, n_rem;
    logic [SPAN_W-1:0] r_dsh, n_dsh;
    logic [AW-1:0]     r_q, n_q;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic              r_done, n_done;
    logic              ge;

    // Restoring division, one quotient bit per cycle, most significant first.
    always_comb begin
        n_rem  = r_rem;
        n_dsh  = r_dsh;
        n_q    = r_q;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        ge     = r_rem >= r_dsh;
        if (i_start) begin
            n_rem = i_dividend;
            n_dsh = SPAN_W'(i_divisor) << (AW - 1);
            n_q   = '0;
            n_cnt = CW'(AW);
        end else if (r_cnt != '0) begin
            if (ge) begin
                n_rem = r_rem - r_dsh;
            end
            n_dsh  = r_dsh >> 1;
            n_q    = AW'({r_q, ge});
            n_cnt  = r_cnt - 1'b1;
            n_done = r_cnt == CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dsh <= n_dsh;
        r_q   <= n_q;
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ----- hw/rtl/fspa_back.sv -----
module fspa_back import fspa_pkg::*; #(
    parameter int POOL_SLOTS = POOL_SLOTS_DEF,
    localparam int LW = $clog2(POOL_SLOTS + 1),
    localparam int SPAN_W = UNIT_W + LW,
    localparam int AW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [ADDR_W-1:0] i_base,
    input  logic [UNIT_W-1:0] i_units,
    input  logic              i_q_valid,
    input  t_kind             i_q_kind,
    input  logic [SPAN_W-1:0] i_q_offset,
    output logic              o_q_pop,
    output logic              o_init_busy,
    fspa_out_if.source        o_out
);

    localparam logic [LW-1:0] NO_SLOT = LW'(POOL_SLOTS);

    t_state            r_state, n_state;
    logic [LW-1:0]     r_head, n_head;
    logic [LW-1:0]     r_init, n_init;
    logic              r_ov, n_ov;
    logic [SPAN_W-1:0] r_prod, n_prod;
    logic [ADDR_W-1:0] r_oaddr, n_oaddr;
    t_status           r_ostat, n_ostat;
    t_status           r_rstat, n_rstat;
    logic [LW-1:0]     r_link [POOL_SLOTS];
    logic [LW-1:0]     r_rdata;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [LW-1:0]     mem_wdata;
    logic              mem_re;
    logic              out_free;
    logic              div_start;
    logic              div_done;
    logic [AW-1:0]     div_quot;

    fspa_div #(
        .POOL_SLOTS(POOL_SLOTS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_q_offset),
        .i_divisor  (i_units),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_init    = r_init;
        n_ov      = r_ov;
        n_prod    = r_prod;
        n_oaddr   = r_oaddr;
        n_ostat   = r_ostat;
        n_rstat   = r_rstat;
        mem_we    = 1'b0;
        mem_waddr = r_init[AW-1:0];
        mem_wdata = r_init + 1'b1;
        mem_re    = 1'b0;
        o_q_pop   = 1'b0;
        div_start = 1'b0;
        out_free  = !r_ov || o_out.ready;
        if (r_ov && o_out.ready) begin
            n_ov = 1'b0;
        end
        unique case (r_state)
            S_INIT: begin
                // Sweep the link memory so that slot i points at slot i+1.
                mem_we = 1'b1;
                n_init = r_init + 1'b1;
                if (r_init == LW'(POOL_SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    unique case (i_q_kind)
                        K_ALLOC: begin
                            if (r_head == NO_SLOT) begin
                                n_rstat = ST_EMPTY;
                                n_state = S_REPLY;
                            end else begin
                                mem_re  = 1'b1;
                                n_prod  = SPAN_W'(r_head) * SPAN_W'(i_units);
                                n_state = S_ALLOC_FIN;
                            end
                        end
                        K_FREE: begin
                            div_start = 1'b1;
                            n_state   = S_DIV;
                        end
                        default: begin
                            n_rstat = ST_OOB;
                            n_state = S_REPLY;
                        end
                    endcase
                end
            end
            S_ALLOC_FIN: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_oaddr = i_base + ADDR_W'({r_prod, 3'b000});
                    n_ostat = ST_OK;
                    n_head  = r_rdata;
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_FREE_FIN;
                end
            end
            S_FREE_FIN: begin
                if (out_free) begin
                    mem_we    = 1'b1;
                    mem_waddr = div_quot;
                    mem_wdata = r_head;
                    n_head    = LW'(div_quot);
                    n_ov      = 1'b1;
                    n_oaddr   = '0;
                    n_ostat   = ST_OK;
                    n_state   = S_IDLE;
                end
            end
            S_REPLY: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_oaddr = '0;
                    n_ostat = r_rstat;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_init <= '0;
            r_ov   <= 1'b0;
        end else begin
            r_head <= n_head;
            r_init <= n_init;
            r_ov   <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= n_prod;
        r_oaddr <= n_oaddr;
        r_ostat <= n_ostat;
        r_rstat <= n_rstat;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_link[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_link[r_head[AW-1:0]];
        end
    end

    assign o_init_busy        = r_state == S_INIT;
    assign o_out.valid        = r_ov;
    assign o_out.slot_address = r_oaddr;
    assign o_out.status       = r_ostat;

endmodule

// ----- hw/rtl/fixed_slot_pool_allocator.sv -----
// Each accepted word is queued and then handled one at a time by the back end: an
// allocate reads the link memory, then updates the head; a free waits for the
// bit-serial divider to find the slot index, then links that slot in at the head.
// Out-of-range words go straight to a reply.
// Reset (synchronous, active low) starts a sweep over all POOL_SLOTS slots that
// builds the free list in the link memory; no input word is accepted until it ends.
module fixed_slot_pool_allocator import fspa_pkg::*; #(
    parameter int POOL_SLOTS = POOL_SLOTS_DEF,
    localparam int LW = $clog2(POOL_SLOTS + 1),
    localparam int SPAN_W = UNIT_W + LW,
    localparam int QDW = KIND_W + SPAN_W
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fspa_cfg_if.sink   i_cfg,
    fspa_in_if.sink    i_in,
    fspa_out_if.source o_out
);

    logic [ADDR_W-1:0] r_base, n_base;
    logic [UNIT_W-1:0] r_units, n_units;
    logic [OBJ_W:0]    obj_sum;
    logic              push;
    t_kind             front_kind;
    logic [SPAN_W-1:0] front_offset;
    logic              q_ready;
    logic              q_valid;
    logic              q_pop;
    logic [QDW-1:0]    q_rdata;
    logic              init_busy;

    // The slot size is kept in units of eight bytes, at least one unit.
    always_comb begin
        n_base  = r_base;
        n_units = r_units;
        obj_sum = {1'b0, i_cfg.data[OBJ_W-1:0]} + (OBJ_W + 1)'(7);
        if (i_cfg.valid) begin
            unique case (t_cfg_reg'(i_cfg.index))
                REG_BASE: begin
                    n_base = i_cfg.data[ADDR_W-1:0];
                end
                REG_OBJ: begin
                    if (i_cfg.data[OBJ_W-1:0] == '0) begin
                        n_units = UNIT_W'(1);
                    end else begin
                        n_units = UNIT_W'(obj_sum >> 3);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_units <= UNIT_W'(1);
        end else begin
            r_base  <= n_base;
            r_units <= n_units;
        end
    end

    assign i_cfg.ready = 1'b1;

    fspa_front #(
        .POOL_SLOTS(POOL_SLOTS)
    ) u_front (
        .i_in      (i_in),
        .i_base    (r_base),
        .i_units   (r_units),
        .i_hold    (init_busy),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_kind    (front_kind),
        .o_offset  (front_offset)
    );

    fspa_queue #(
        .DW(QDW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata ({front_kind, front_offset}),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_rdata (q_rdata)
    );

    fspa_back #(
        .POOL_SLOTS(POOL_SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_base      (r_base),
        .i_units     (r_units),
        .i_q_valid   (q_valid),
        .i_q_kind    (t_kind'(q_rdata[QDW-1 -: KIND_W])),
        .i_q_offset  (q_rdata[SPAN_W-1:0]),
        .o_q_pop     (q_pop),
        .o_init_busy (init_busy),
        .o_out       (o_out)
    );

endmodule

// ----- hw/rtl/fspa_checker.sv -----
module fspa_checker import fspa_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [ADDR_W-1:0] i_out_addr,
    input logic [STAT_W-1:0] i_out_status
);

    // The free list is rebuilt after reset before any word is taken.
    a_no_accept_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("input ready while the free list is rebuilt");

    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result word right after reset");

    a_error_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_status != ST_OK) |-> i_out_addr == '0)
        else $error("nonzero slot address with an error status");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_addr) && $stable(i_out_status))
        else $error("stalled result word changed");

endmodule

bind fixed_slot_pool_allocator fspa_checker u_fspa_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_addr   (o_out.slot_address),
    .i_out_status (o_out.status)
);

// ----- verif/testbench.sv -----
module testbench;
    import fspa_pkg::*;

    localparam int          SLOTS      = POOL_SLOTS_DEF;
    localparam logic [10:0] NO_SLOT    = 11'(SLOTS);
    localparam int          IDLE_LIMIT = 4000;
    localparam logic [47:0] ADDR_ONES  = '1;
    localparam logic        MODE_ALLOC = 1'b0;
    localparam logic        MODE_FREE  = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0] slot_address;
        t_status           status;
    } pool_reply_t;

    logic clk;
    logic rst_n;

    fspa_in_if  in_bus();
    fspa_out_if out_bus();
    fspa_cfg_if cfg_bus();

    fixed_slot_pool_allocator #(.POOL_SLOTS(SLOTS)) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_bus.sink),
        .i_in    (in_bus.sink),
        .o_out   (out_bus.source)
    );

    // Shadow copy of the free list and the configuration.
    logic [10:0]       link_table [SLOTS];
    logic [10:0]       head_index;
    logic [ADDR_W-1:0] cfg_base;
    logic [OBJ_W-1:0]  cfg_obj;

    pool_reply_t pending_replies[$];
    int          held_slots[$];
    int          burst_left = 0;
    int          errors = 0;
    int          idle_cycles = 0;
    int          stall_pct = 0;
    logic [31:0] stall_cycle = '0;

    initial begin
        clk = 1'b0;
    end

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [47:0] rand48();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[47:0];
    endfunction

    function automatic logic [63:0] slot_bytes();
        logic [63:0] v;
        v = (cfg_obj < 17'd8) ? 64'd8 : 64'(cfg_obj);
        return (v + 64'd7) & ~64'd7;
    endfunction

    function automatic logic [47:0] slot_address_of(int idx, int offset);
        logic [63:0] sum;
        sum = 64'(cfg_base) + 64'(idx) * slot_bytes() + 64'(offset);
        return sum[47:0];
    endfunction

    function automatic void forget_held(int idx);
        for (int k = 0; k < held_slots.size(); k++) begin
            if (held_slots[k] == idx) begin
                held_slots.delete(k);
                return;
            end
        end
    endfunction

    function automatic pool_reply_t predict_reply(logic mode, logic [47:0] addr);
        pool_reply_t r;
        logic [63:0] size;
        logic [63:0] span;
        logic [63:0] idx64;
        int          idx;
        r.slot_address = '0;
        r.status = ST_OK;
        size = slot_bytes();
        if (mode == MODE_ALLOC) begin
            if (head_index >= NO_SLOT) begin
                r.status = ST_EMPTY;
            end else begin
                idx = int'(head_index);
                r.slot_address = slot_address_of(idx, 0);
                head_index = link_table[idx];
                held_slots.push_back(idx);
            end
        end else begin
            span = size * 64'(SLOTS);
            if (addr < cfg_base || 64'(addr) - 64'(cfg_base) >= span) begin
                r.status = ST_OOB;
            end else begin
                idx64 = (64'(addr) - 64'(cfg_base)) / size;
                idx = int'(idx64);
                link_table[idx] = head_index;
                head_index = 11'(idx);
                forget_held(idx);
            end
        end
        return r;
    endfunction

    task automatic send_request(input logic mode, input logic [47:0] addr);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 5) == 0) ? 64 : $urandom_range(1, 16);
            if (gap > 0) begin
                in_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_bus.valid        <= 1'b1;
        in_bus.mode         <= mode;
        in_bus.free_address <= addr;
        do @(posedge clk); while (!in_bus.ready);
        burst_left--;
        pending_replies.push_back(predict_reply(mode, addr));
    endtask

    task automatic request_slot();
        send_request(MODE_ALLOC, rand48());
    endtask

    task automatic free_random_held();
        int k;
        if (held_slots.size() == 0) begin
            request_slot();
        end else begin
            k = $urandom_range(0, held_slots.size() - 1);
            send_request(MODE_FREE, slot_address_of(held_slots[k],
                         $urandom_range(0, int'(slot_bytes()) - 1)));
        end
    endtask

    task automatic wait_for_replies();
        in_bus.valid <= 1'b0;
        burst_left = 0;
        while (pending_replies.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Both registers are written back to back, only once the pool has gone quiet.
    task automatic set_pool_config(input logic [47:0] base, input logic [47:0] obj_data);
        wait_for_replies();
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= REG_BASE;
        cfg_bus.data  <= base;
        do @(posedge clk); while (!cfg_bus.ready);
        cfg_base = base;
        cfg_bus.index <= REG_OBJ;
        cfg_bus.data  <= obj_data;
        do @(posedge clk); while (!cfg_bus.ready);
        cfg_obj = obj_data[OBJ_W-1:0];
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic randomize_pool_config();
        logic [47:0] base;
        logic [16:0] obj;
        logic [30:0] junk;
        case ($urandom_range(0, 4))
            0: base = '0;
            1: base = ADDR_ONES - 48'($urandom_range(0, 4096));
            2: base = rand48();
            default: base = rand48() & 48'h0000_FFFF_FFF8;
        endcase
        case ($urandom_range(0, 9))
            0: obj = 17'($urandom_range(0, 7));
            1: obj = 17'($urandom_range(65529, 131071));
            2: obj = 17'h1FFFF;
            default: obj = 17'($urandom_range(8, 256));
        endcase
        junk = ($urandom_range(0, 3) == 0) ? 31'($urandom()) : '0;
        set_pool_config(base, {junk, obj});
    endtask

    task automatic test_reset_layout();
        repeat (3) request_slot();
        send_request(MODE_FREE, 48'd8);
        request_slot();
        send_request(MODE_FREE, 48'd8192);
        send_request(MODE_FREE, ADDR_ONES);
    endtask

    task automatic test_size_rounding();
        logic [47:0] base;
        base = 48'h0000_1000_0000;
        set_pool_config(base, 48'd0);
        request_slot();
        send_request(MODE_FREE, base - 48'd1);
        set_pool_config(base, 48'd9);
        request_slot();
        send_request(MODE_FREE, slot_address_of(held_slots[$], int'(slot_bytes()) - 1));
        set_pool_config(base, 48'd65529);
        request_slot();
        set_pool_config(base, 48'h1FFFF);
        request_slot();
        send_request(MODE_FREE, slot_address_of(SLOTS, 0));
        send_request(MODE_FREE, 48'd0);
    endtask

    task automatic test_address_wrap();
        set_pool_config(ADDR_ONES - 48'd23, 48'd8);
        request_slot();
        request_slot();
        send_request(MODE_FREE, ADDR_ONES);
        send_request(MODE_FREE, slot_address_of(held_slots[$], 0));
    endtask

    task automatic test_pool_exhaustion();
        randomize_pool_config();
        for (int n = 0; n < SLOTS && head_index != NO_SLOT; n++) request_slot();
        repeat (4) request_slot();
        repeat (200) free_random_held();
    endtask

    task automatic test_random_traffic();
        repeat (6) begin
            randomize_pool_config();
            repeat (90) begin
                if ($urandom_range(0, 1) == 0) begin
                    request_slot();
                end else if ($urandom_range(0, 4) != 0) begin
                    free_random_held();
                end else begin
                    case ($urandom_range(0, 2))
                        0: send_request(MODE_FREE, rand48());
                        1: send_request(MODE_FREE, cfg_base - 48'd1);
                        default: send_request(MODE_FREE, slot_address_of(SLOTS, 0));
                    endcase
                end
            end
        end
    endtask

    // A second free of the same slot leaves it linked to itself, so this runs last.
    task automatic test_double_free();
        logic [47:0] addr;
        set_pool_config(48'd0, 48'd8);
        request_slot();
        addr = slot_address_of(held_slots[$], 0);
        send_request(MODE_FREE, addr);
        send_request(MODE_FREE, addr);
        request_slot();
        request_slot();
    endtask

    always @(posedge clk) begin
        stall_cycle <= stall_cycle + 32'd1;
        if (stall_cycle[7:0] == 8'd0) begin
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 25;
                2: stall_pct = 60;
                default: stall_pct = 85;
            endcase
        end
        out_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk) begin : reply_checker
        pool_reply_t want;
        if (rst_n && out_bus.valid && out_bus.ready) begin
            if (pending_replies.size() == 0) begin
                $error("unexpected word: slot_address %h status %0d",
                       out_bus.slot_address, out_bus.status);
                errors++;
            end else begin
                want = pending_replies.pop_front();
                if (out_bus.slot_address !== want.slot_address) begin
                    $error("slot_address: expected %h, got %h",
                           want.slot_address, out_bus.slot_address);
                    errors++;
                end
                if (out_bus.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, out_bus.status);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)
                || (cfg_bus.valid && cfg_bus.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        rst_n               <= 1'b0;
        in_bus.valid        <= 1'b0;
        in_bus.mode         <= MODE_ALLOC;
        in_bus.free_address <= '0;
        cfg_bus.valid       <= 1'b0;
        cfg_bus.index       <= REG_BASE;
        cfg_bus.data        <= '0;
        for (int i = 0; i < SLOTS; i++) link_table[i] = 11'(i + 1);
        head_index = '0;
        cfg_base = '0;
        cfg_obj = 17'd8;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_layout();
        test_size_rounding();
        test_address_wrap();
        test_pool_exhaustion();
        test_random_traffic();
        test_double_free();
        wait_for_replies();
        repeat (20) @(posedge clk);
        if (errors == 0 && pending_replies.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/fspa_pkg.sv
hw/rtl/fspa_if.sv
hw/rtl/fspa_front.sv
hw/rtl/fspa_queue.sv
hw/rtl/fspa_div.sv
hw/rtl/fspa_back.sv
hw/rtl/fixed_slot_pool_allocator.sv
hw/rtl/fspa_checker.sv
verif/testbench.sv
